// ===== rtl/tbh_pkg.sv =====
package tbh_pkg;

    // configuration register indexes
    localparam int CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] CFG_INTEGRAL_GAIN      = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_FALLING_DERIV_GAIN = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_RISING_DERIV_GAIN  = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_INVERSE_INTERVAL   = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_DRIVE_MIN          = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_DRIVE_MAX          = 3'd5;

    localparam int CfgDataW = 32;

    // reset values of the configuration registers
    localparam logic [15:0] RST_INTEGRAL_GAIN      = 16'd4096;
    localparam logic [15:0] RST_FALLING_DERIV_GAIN = 16'd819;
    localparam logic [15:0] RST_RISING_DERIV_GAIN  = 16'd1638;
    localparam logic [15:0] RST_INVERSE_INTERVAL   = 16'd256;
    localparam logic [31:0] RST_DRIVE_MIN          = 32'sd0;
    localparam logic [31:0] RST_DRIVE_MAX          = 32'sd409600;

    typedef struct packed {
        logic signed [15:0] target_temp;
        logic signed [15:0] measured_temp;
        logic               enable_ctl;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drive_out;
        logic               crossing_seen;
    } out_word_t;

    // sequencer commands to the datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic damp;
        logic sum;
        logic fin;
    } tbh_cmd_t;

endpackage

// ===== rtl/tbh_ctrl.sv =====
module tbh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output tbh_pkg::tbh_cmd_t cmd
);
    import tbh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DAMP = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                cmd.damp = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // state update and result load wait for a free output slot
                if (out_free)
                begin
                    cmd.fin = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.fin)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_fin_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> out_free)
        else $error("result loaded over an untaken word");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL))
        else $error("accepted word did not start the sequence");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.fin))
        else $error("output valid without a finished word");
`endif

endmodule

// ===== rtl/tbh_datapath.sv =====
module tbh_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tbh_pkg::tbh_cmd_t                cmd,
    input  tbh_pkg::in_word_t                in_word,
    output tbh_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [tbh_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [tbh_pkg::CfgDataW-1:0]     cfg_data
);
    import tbh_pkg::*;

    // configuration
    logic        [15:0] gain_reg;
    logic        [15:0] beta_fall_reg;
    logic        [15:0] beta_rise_reg;
    logic        [15:0] inv_int_reg;
    logic signed [31:0] drive_min_reg;
    logic signed [31:0] drive_max_reg;

    // controller state
    logic signed [15:0] last_temp_reg;
    logic signed [31:0] drive_acc_reg;
    logic signed [31:0] drive_cross_reg;
    logic signed [16:0] err_cross_reg;
    logic               running_reg;
    logic               armed_reg;

    // per-word working registers
    in_word_t           in_reg;
    logic signed [16:0] err_reg;
    logic signed [29:0] integ_reg;
    logic signed [33:0] deriv_reg;
    logic signed [38:0] damp_reg;
    logic signed [31:0] drive_reg;
    out_word_t          out_reg;

    logic signed [16:0] err_next;
    logic signed [16:0] diff_next;
    logic signed [33:0] integ_prod;
    logic signed [33:0] deriv_prod;
    logic        [15:0] beta_sel;
    logic signed [50:0] damp_prod;
    logic signed [40:0] sum_next;
    logic signed [31:0] drive_next;
    logic               rise;
    logic               armed_eff;
    logic signed [31:0] acc_eff;
    logic signed [31:0] dcross_eff;
    logic               err_pos;
    logic               err_neg;
    logic               ecross_pos;
    logic               ecross_neg;
    logic               crossed;
    logic signed [32:0] avg_sum;
    logic signed [31:0] avg;
    logic signed [31:0] final_drive;

    assign err_next  = {in_reg.target_temp[15], in_reg.target_temp}
                     - {in_reg.measured_temp[15], in_reg.measured_temp};
    assign diff_next = {in_reg.measured_temp[15], in_reg.measured_temp}
                     - {last_temp_reg[15], last_temp_reg};
    assign integ_prod = $signed({1'b0, gain_reg}) * err_next;
    assign deriv_prod = diff_next * $signed({1'b0, inv_int_reg});

    assign err_pos    = !err_reg[16] && (err_reg != '0);
    assign err_neg    = err_reg[16];
    assign ecross_pos = !err_cross_reg[16] && (err_cross_reg != '0);
    assign ecross_neg = err_cross_reg[16];

    // damping only when error and slope disagree
    always_comb
    begin
        beta_sel = '0;
        if (err_pos && deriv_reg[33])
            beta_sel = beta_fall_reg;
        else if (err_neg && !deriv_reg[33] && (deriv_reg != '0))
            beta_sel = beta_rise_reg;
    end
    assign damp_prod = $signed({1'b0, beta_sel}) * deriv_reg;

    // a rising enable restarts the drive and crossing history
    assign rise       = in_reg.enable_ctl && !running_reg;
    assign armed_eff  = armed_reg && !rise;
    assign acc_eff    = rise ? '0 : drive_acc_reg;
    assign dcross_eff = rise ? '0 : drive_cross_reg;

    assign sum_next = {{9{acc_eff[31]}}, acc_eff}
                    + {{11{integ_reg[29]}}, integ_reg}
                    - {{2{damp_reg[38]}}, damp_reg};

    always_comb
    begin
        if (sum_next < $signed({{9{drive_min_reg[31]}}, drive_min_reg}))
            drive_next = drive_min_reg;
        else if (sum_next > $signed({{9{drive_max_reg[31]}}, drive_max_reg}))
            drive_next = drive_max_reg;
        else
            drive_next = sum_next[31:0];
    end

    assign crossed = in_reg.enable_ctl && armed_eff
                   && ((err_pos && ecross_neg) || (err_neg && ecross_pos));
    assign avg_sum = {drive_reg[31], drive_reg} + {dcross_eff[31], dcross_eff};
    assign avg     = avg_sum[32:1];
    assign final_drive = crossed ? avg : drive_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_word;
        if (cmd.mul)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_prod[33:4];
            deriv_reg <= deriv_prod;
        end
        if (cmd.damp)
            damp_reg <= damp_prod[50:12];
        if (cmd.sum)
            drive_reg <= drive_next;
        if (cmd.fin)
        begin
            out_reg.drive_out     <= in_reg.enable_ctl ? final_drive : drive_acc_reg;
            out_reg.crossing_seen <= crossed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= RST_INTEGRAL_GAIN;
            beta_fall_reg   <= RST_FALLING_DERIV_GAIN;
            beta_rise_reg   <= RST_RISING_DERIV_GAIN;
            inv_int_reg     <= RST_INVERSE_INTERVAL;
            drive_min_reg   <= RST_DRIVE_MIN;
            drive_max_reg   <= RST_DRIVE_MAX;
            last_temp_reg   <= '0;
            drive_acc_reg   <= '0;
            drive_cross_reg <= '0;
            err_cross_reg   <= '0;
            running_reg     <= 1'b0;
            armed_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INTEGRAL_GAIN:      gain_reg      <= cfg_data[15:0];
                    CFG_FALLING_DERIV_GAIN: beta_fall_reg <= cfg_data[15:0];
                    CFG_RISING_DERIV_GAIN:  beta_rise_reg <= cfg_data[15:0];
                    CFG_INVERSE_INTERVAL:   inv_int_reg   <= cfg_data[15:0];
                    CFG_DRIVE_MIN:          drive_min_reg <= cfg_data;
                    CFG_DRIVE_MAX:          drive_max_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (cmd.fin)
            begin
                last_temp_reg <= in_reg.measured_temp;
                running_reg   <= in_reg.enable_ctl;
                if (in_reg.enable_ctl)
                begin
                    drive_acc_reg   <= final_drive;
                    drive_cross_reg <= crossed ? avg : dcross_eff;
                    // first nonzero error arms the crossing detector
                    armed_reg       <= armed_eff || (err_reg != '0);
                    if (crossed || (!armed_eff && (err_reg != '0)))
                        err_cross_reg <= err_reg;
                end
            end
        end
    end

    assign out_word = out_reg;

endmodule

// ===== rtl/take_back_half_temp_controller_core.sv =====
// take-back-half temperature controller
//
// input channel: in_valid / in_stall carry one sample word (target and
// measured temperature, signed Q12.4, and the enable bit). a word is taken
// at a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry one result word per sample
// (drive in signed Q20.12 and the crossing flag).
// configuration: cfg_we writes cfg_data into the register picked by
// cfg_index (gain, falling and rising damping gains, inverse interval,
// drive min and max); write only while no sample is in flight.
// steps: after accept, the sequencer runs the error and slope multiply, the
// damping multiply, sum and clamp, then crossing update and result load.
// a new sample is taken only while the single sequencer is idle; it walks
// every sample through its multiply and update steps.
// a finished word waits in the output register; while out_stall holds it
// the next sample parks in the sequencer's last step and in_stall stays high.
// reset (rst_n low, asynchronous) restores register defaults, clears the
// drive, crossing history and last temperature, and empties the output.
module take_back_half_temp_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tbh_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbh_pkg::out_word_t            out_word,
    input  logic                          cfg_we,
    input  logic [tbh_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tbh_pkg::CfgDataW-1:0]  cfg_data
);
    import tbh_pkg::*;

    // sequencer to datapath command bundle
    tbh_cmd_t cmd;

    // sequencer: handshakes and step order
    tbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: config registers, controller state, multiplies, result register
    tbh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tbh_pkg::*;

    // cycles with no handshake or register write before the run is declared hung
    localparam int QUIET_LIMIT = 3000;
    // settle time after the last drive word
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES = 8;
    localparam int PHASE_SAMPLES = 240;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_word;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_word;
    logic       cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    take_back_half_temp_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sample words waiting for the driver, and drive words the block owes us
    in_word_t  sample_q[$];
    out_word_t drive_due_q[$];

    int n_pushed;
    int n_accepted;
    int n_checked;
    int n_crossings;
    int n_fail;
    int n_settings;
    int quiet_cycles;
    bit word_taken;
    bit moved;
    out_word_t want;

    // idle percentages for the current phase
    int send_idle_pct;
    int recv_stall_pct;

    // shadow of the configuration registers, starts at the reset values
    int gain_int  = int'(RST_INTEGRAL_GAIN);
    int gain_fall = int'(RST_FALLING_DERIV_GAIN);
    int gain_rise = int'(RST_RISING_DERIV_GAIN);
    int inv_dt    = int'(RST_INVERSE_INTERVAL);
    int drive_lo  = int'($signed(RST_DRIVE_MIN));
    int drive_hi  = int'($signed(RST_DRIVE_MAX));

    // controller state as the block should hold it
    int     prev_meas;
    int     acc;
    int     cross_drive;
    longint cross_err;
    bit     run_on;
    bit     armed;

    // temperature walk used to build plausible control loops
    int walk_target;
    int walk_meas;
    bit walk_en;

    // one sample through the controller: returns the drive word it produces
    function automatic out_word_t predict_drive(in_word_t w);
        longint err;
        longint slope;
        longint drive;
        longint meas;
        bit crossed;
        out_word_t r;
        crossed = 1'b0;
        meas = longint'($signed(w.measured_temp));
        slope = (meas - longint'(prev_meas)) * longint'(inv_dt);
        // measurement is stored whether or not the loop runs
        prev_meas = int'(meas);
        // rising enable starts the loop from scratch
        if (w.enable_ctl && !run_on) begin
            acc = 0;
            cross_drive = 0;
            armed = 1'b0;
        end
        run_on = w.enable_ctl;
        if (w.enable_ctl) begin
            err = longint'($signed(w.target_temp)) - meas;
            drive = longint'(acc) + ((longint'(gain_int) * err) >>> 4);
            // damping only when error and slope point opposite ways
            if (err > 0 && slope < 0)
                drive = drive - ((longint'(gain_fall) * slope) >>> 12);
            else if (err < 0 && slope > 0)
                drive = drive - ((longint'(gain_rise) * slope) >>> 12);
            // min is checked first, so when min > max a drive below min gets min, any other max
            if (drive < longint'(drive_lo))
                drive = longint'(drive_lo);
            else if (drive > longint'(drive_hi))
                drive = longint'(drive_hi);
            if (armed) begin
                // sign flip against the last crossing: take back half
                if ((err > 0 && cross_err < 0) || (err < 0 && cross_err > 0)) begin
                    drive = (drive + longint'(cross_drive)) >>> 1;
                    cross_err = err;
                    cross_drive = int'(drive);
                    crossed = 1'b1;
                end
            end else if (err != 0) begin
                // first nonzero error arms the crossing detector
                cross_err = err;
                armed = 1'b1;
            end
            acc = int'(drive);
        end
        r.drive_out = acc;
        r.crossing_seen = crossed;
        return r;
    endfunction

    task automatic push_sample(input int tgt, input int meas, input bit en);
        in_word_t w;
        w.target_temp = tgt[15:0];
        w.measured_temp = meas[15:0];
        w.enable_ctl = en;
        sample_q.push_back(w);
        n_pushed++;
    endtask

    // mostly a measured temperature chasing a target with noise, so the
    // error keeps changing sign; a few raw random words and enable drops
    task automatic add_random(input int count);
        in_word_t w;
        int step;
        repeat (count) begin
            if ($urandom_range(99) < 8) begin
                w.target_temp = 16'($urandom);
                w.measured_temp = 16'($urandom);
                w.enable_ctl = 1'($urandom_range(1));
                sample_q.push_back(w);
                n_pushed++;
            end else begin
                if (walk_en)
                    walk_en = ($urandom_range(99) >= 3);
                else
                    walk_en = ($urandom_range(99) < 30);
                if ($urandom_range(99) < 4)
                    walk_target = int'($urandom_range(8000)) - 4000;
                else if ($urandom_range(199) == 0)
                    walk_target = $urandom_range(1) ? 32767 : -32768;
                step = int'($urandom_range(128)) - 64;
                walk_meas = walk_meas + (walk_target - walk_meas) / 4 + step;
                if (walk_meas > 32767)
                    walk_meas = 32767;
                else if (walk_meas < -32768)
                    walk_meas = -32768;
                push_sample(walk_target, walk_meas, walk_en);
            end
        end
    endtask

    // pause the sender until every drive word is back and the block is quiet
    task automatic wait_drained();
        while (n_accepted != n_pushed || drive_due_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
    endtask

    // back to back writes, write enable dropped once after the last one
    task automatic set_regs(input logic [31:0] gain, input logic [31:0] fall,
                            input logic [31:0] rise, input logic [31:0] inv,
                            input logic [31:0] lo, input logic [31:0] hi);
        write_reg(CFG_INTEGRAL_GAIN, gain);
        write_reg(CFG_FALLING_DERIV_GAIN, fall);
        write_reg(CFG_RISING_DERIV_GAIN, rise);
        write_reg(CFG_INVERSE_INTERVAL, inv);
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: a sample word is held until taken, then the next one may
    // follow right away or after a random idle gap
    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            if (!in_valid || word_taken) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_word <= sample_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            word_taken = 1'b0;
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: tracks register writes, predicts on every accepted sample
    // word and checks every accepted drive word against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n) begin
            moved = 1'b0;
            if (cfg_we) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_INTEGRAL_GAIN:      gain_int = int'(cfg_data[15:0]);
                    CFG_FALLING_DERIV_GAIN: gain_fall = int'(cfg_data[15:0]);
                    CFG_RISING_DERIV_GAIN:  gain_rise = int'(cfg_data[15:0]);
                    CFG_INVERSE_INTERVAL:   inv_dt = int'(cfg_data[15:0]);
                    CFG_DRIVE_MIN:          drive_lo = int'($signed(cfg_data));
                    CFG_DRIVE_MAX:          drive_hi = int'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                drive_due_q.push_back(predict_drive(in_word));
                n_accepted++;
                word_taken = 1'b1;
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                if (drive_due_q.size() == 0) begin
                    $error("drive word with no sample outstanding: drive_out %0d",
                           $signed(out_word.drive_out));
                    n_fail++;
                end else begin
                    want = drive_due_q.pop_front();
                    n_checked++;
                    if (want.crossing_seen)
                        n_crossings++;
                    if (out_word.drive_out !== want.drive_out) begin
                        $error("drive_out mismatch: expected %0d, actual %0d",
                               $signed(want.drive_out), $signed(out_word.drive_out));
                        n_fail++;
                    end
                    if (out_word.crossing_seen !== want.crossing_seen) begin
                        $error("crossing_seen mismatch: expected %0b, actual %0b",
                               want.crossing_seen, out_word.crossing_seen);
                        n_fail++;
                    end
                end
            end
            // watchdog on handshakes
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d drive words owed",
                         quiet_cycles, drive_due_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        walk_target = 0;
        walk_meas = 0;
        walk_en = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            // idle pattern rotates: none, sender, receiver, both
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            case (p)
                0: ;  // reset defaults
                1: set_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                            32'h8000_0000, 32'h7FFF_FFFF);
                2: set_regs(32'd0, 32'd0, 32'd0, 32'd1, -32'sd409600, 32'sd409600);
                // zero inverse interval, and a min clamp above the max clamp
                3: set_regs($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), 32'd0, 32'sd100000, -32'sd100000);
                default: set_regs($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(1024),
                                  -int'($urandom_range(1 << 26)),
                                  int'($urandom_range(1 << 26)));
            endcase
            if (p == 0) begin
                // disabled words at the field extremes only move last temp
                push_sample(32767, -32768, 1'b0);
                push_sample(-32768, 32767, 1'b0);
                // rising enable with zero error leaves the detector unarmed
                push_sample(400, 400, 1'b1);
                push_sample(1600, 400, 1'b1);
                // falling slope under positive error, then both sign flips
                push_sample(1600, 300, 1'b1);
                push_sample(1600, 1700, 1'b1);
                push_sample(1600, 1500, 1'b1);
                push_sample(1600, 1600, 1'b1);
                // drive pinned at the top, then at the bottom
                push_sample(32767, -32768, 1'b1);
                push_sample(-32768, 32767, 1'b1);
                // hold while disabled, then a fresh start
                push_sample(0, 0, 1'b0);
                push_sample(-100, 100, 1'b1);
                push_sample(200, 100, 1'b1);
                push_sample(200, 32767, 1'b1);
                push_sample(200, -32768, 1'b1);
                push_sample(0, 0, 1'b0);
                add_random(PHASE_SAMPLES - 16);
            end else if (p == 4) begin
                // sender holds off mid phase until everything is back
                add_random(PHASE_SAMPLES / 2);
                wait_drained();
                add_random(PHASE_SAMPLES / 2);
            end else begin
                add_random(PHASE_SAMPLES);
            end
            wait_drained();
        end

        $display("%0d sample words over %0d register settings, idle mixes from none to 66%%",
                 n_accepted, n_settings + 1);
        $display("%0d drive words compared, %0d with take-back-half averaging, %0d mismatches",
                 n_checked, n_crossings, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== take_back_half_temp_controller_core.f =====
rtl/tbh_pkg.sv
rtl/tbh_ctrl.sv
rtl/tbh_datapath.sv
rtl/take_back_half_temp_controller_core.sv
dv/tb_top.sv
